@@ src/binc_pkg.sv @@
package binc_pkg;

   localparam int TIMEOUT_BITS = 31;
   localparam int TOD_BITS     = 17;
   localparam int LEVEL_BITS   = 7;
   localparam int OP_BITS      = 2;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 31;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 16;

   localparam logic [TIMEOUT_BITS-1:0] MIN_TIMEOUT   = TIMEOUT_BITS'(1000);
   localparam logic [TIMEOUT_BITS-1:0] RESET_TIMEOUT = TIMEOUT_BITS'(60000);
   localparam logic [LEVEL_BITS-1:0]   MAX_LEVEL     = LEVEL_BITS'(100);
   localparam logic [LEVEL_BITS-1:0]   MIN_ACTIVE    = LEVEL_BITS'(1);

   typedef enum logic [OP_BITS-1:0] {
      OP_TICK     = 2'd0,
      OP_ACTIVITY = 2'd1,
      OP_SLEEP    = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ENABLED       = 3'd0,
      CSR_IDLE_TIMEOUT  = 3'd1,
      CSR_ACTIVE_BRIGHT = 3'd2,
      CSR_IDLE_BRIGHT   = 3'd3,
      CSR_NIGHT_ENABLED = 3'd4,
      CSR_NIGHT_START   = 3'd5,
      CSR_NIGHT_END     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                    enabled;
      logic [TIMEOUT_BITS-1:0] idle_timeout_ms;
      logic [LEVEL_BITS-1:0]   active_brightness;
      logic [LEVEL_BITS-1:0]   idle_brightness;
      logic                    night_enabled;
      logic [TOD_BITS-1:0]     night_start;
      logic [TOD_BITS-1:0]     night_end;
   } cfg_type;

   typedef struct packed {
      logic                    idle;
      logic                    night;
      logic                    running;
      logic [TIMEOUT_BITS-1:0] countdown;
   } state_type;

   typedef struct packed {
      logic                  is_idle;
      logic                  night_active;
      logic                  idle_changed;
      logic                  bright_valid;
      logic [LEVEL_BITS-1:0] brightness;
   } result_type;

endpackage

@@ src/backlight_idle_night_controller_unit.sv @@
// Screen idle and night-window backlight controller.
// req_ channel: one transfer per event. req_tuser carries the kind (millisecond
// tick, user activity, sleep request); req_tdata carries the time of day in
// seconds, looked at on ticks only.
// rsp_ channel: exactly one transfer per request transfer, in order, giving the
// idle and night flags after the event, whether the idle flag changed, and an
// optional brightness request in percent.
// csr_ port: write enable, register index and data; write only while the block
// has no transfer in flight.
// A request taken is held in the input register and then moved into the response
// register, from which its response transfer is given; the move waits while the
// response register still holds a response that has not been taken.
// One request per cycle is sustained while rsp_tready stays high; the state
// update and the response are computed by combinational compare, decrement and
// selection logic.
// Reset (synchronous): configuration, state and valid registers take defaults;
// screen awake, no night window in force, countdown loaded with 60000 and running.
// When the rsp_ side stalls, the response register holds, the input register
// fills, and req_tready drops until the response is taken.
module backlight_idle_night_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [16:0] time_of_day, [23:17] zero
   input  logic [binc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // [1:0] op
   input  logic [binc_pkg::OP_BITS-1:0]        req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] is_idle, [1] night_active, [2] idle_changed, [3] bright_valid,
   // [10:4] brightness, [15:11] zero
   output logic [binc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                                csr_we,
   input  logic [binc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [binc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import binc_pkg::*;

   cfg_type                 cfg_ff, cfg_in;
   state_type               state_ff;
   state_type               state_in;
   logic                    in_valid_ff, in_valid_in;
   logic [OP_BITS-1:0]      in_op_ff;
   logic [TOD_BITS-1:0]     in_tod_ff;
   logic                    out_valid_ff, out_valid_in;
   result_type              out_res_ff;
   result_type              step_res;
   logic                    advance;
   logic                    take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   binc_step u_step (
      .cfg         (cfg_ff),
      .cur         (state_ff),
      .op          (in_op_ff),
      .time_of_day (in_tod_ff),
      .nxt         (state_in),
      .res         (step_res)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLED:       cfg_in.enabled           = csr_wdata[0];
            CSR_IDLE_TIMEOUT:  cfg_in.idle_timeout_ms   = csr_wdata[TIMEOUT_BITS-1:0];
            CSR_ACTIVE_BRIGHT: cfg_in.active_brightness = csr_wdata[LEVEL_BITS-1:0];
            CSR_IDLE_BRIGHT:   cfg_in.idle_brightness   = csr_wdata[LEVEL_BITS-1:0];
            CSR_NIGHT_ENABLED: cfg_in.night_enabled     = csr_wdata[0];
            CSR_NIGHT_START:   cfg_in.night_start       = csr_wdata[TOD_BITS-1:0];
            CSR_NIGHT_END:     cfg_in.night_end         = csr_wdata[TOD_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in  = take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled           <= 1'b1;
         cfg_ff.idle_timeout_ms   <= RESET_TIMEOUT;
         cfg_ff.active_brightness <= MAX_LEVEL;
         cfg_ff.idle_brightness   <= LEVEL_BITS'(10);
         cfg_ff.night_enabled     <= 1'b0;
         cfg_ff.night_start       <= TOD_BITS'(79200);
         cfg_ff.night_end         <= TOD_BITS'(25200);
         state_ff.idle            <= 1'b0;
         state_ff.night           <= 1'b0;
         state_ff.running         <= 1'b1;
         state_ff.countdown       <= RESET_TIMEOUT;
         in_valid_ff              <= 1'b0;
         out_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff  <= req_tuser;
         in_tod_ff <= req_tdata[TOD_BITS-1:0];
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - LEVEL_BITS - 4){1'b0}},
                        out_res_ff.brightness,
                        out_res_ff.bright_valid,
                        out_res_ff.idle_changed,
                        out_res_ff.night_active,
                        out_res_ff.is_idle};

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff.running |-> (state_ff.countdown != '0))
      else $error("countdown running at zero");

   a_night_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff.night |-> (state_ff.idle && !state_ff.running))
      else $error("night window in force while awake or counting");

   a_change_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_res_ff.idle_changed) |-> out_res_ff.bright_valid)
      else $error("idle change without brightness request");

   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("response lost after advance");

endmodule

@@ src/binc_step.sv @@
module binc_step (
   input  binc_pkg::cfg_type                   cfg,
   input  binc_pkg::state_type                 cur,
   input  logic [binc_pkg::OP_BITS-1:0]        op,
   input  logic [binc_pkg::TOD_BITS-1:0]       time_of_day,
   output binc_pkg::state_type                 nxt,
   output binc_pkg::result_type                res
);
   import binc_pkg::*;

   logic                    in_window;
   logic                    night_now;
   logic                    restart_run;
   logic [TIMEOUT_BITS-1:0] restart_count;
   logic [LEVEL_BITS-1:0]   idle_level;
   logic [LEVEL_BITS-1:0]   active_level;
   logic                    req_valid;
   logic [LEVEL_BITS-1:0]   req_level;

   always_comb begin
      if (cfg.night_start == cfg.night_end) begin
         in_window = 1'b0;
      end else if (cfg.night_start < cfg.night_end) begin
         in_window = (time_of_day >= cfg.night_start) && (time_of_day < cfg.night_end);
      end else begin
         in_window = (time_of_day >= cfg.night_start) || (time_of_day < cfg.night_end);
      end
      night_now = cfg.night_enabled && in_window;
   end

   always_comb begin
      restart_run   = (cfg.idle_timeout_ms != '0);
      restart_count = (cfg.idle_timeout_ms < MIN_TIMEOUT) ? MIN_TIMEOUT : cfg.idle_timeout_ms;
      idle_level    = (cfg.idle_brightness > MAX_LEVEL) ? MAX_LEVEL : cfg.idle_brightness;
      if (cfg.active_brightness < MIN_ACTIVE) begin
         active_level = MIN_ACTIVE;
      end else if (cfg.active_brightness > MAX_LEVEL) begin
         active_level = MAX_LEVEL;
      end else begin
         active_level = cfg.active_brightness;
      end
   end

   always_comb begin
      nxt       = cur;
      req_valid = 1'b0;
      req_level = '0;
      if (cfg.enabled) begin
         unique case (op)
            OP_TICK: begin
               nxt.night = night_now;
               if (night_now) begin
                  nxt.running = 1'b0;
                  if (!cur.idle) begin
                     nxt.idle  = 1'b1;
                     req_valid = 1'b1;
                     req_level = idle_level;
                  end
               end else if (cur.night) begin
                  if (cur.idle) begin
                     nxt.idle  = 1'b0;
                     req_valid = 1'b1;
                     req_level = active_level;
                  end
                  nxt.running = restart_run;
                  if (restart_run) begin
                     nxt.countdown = restart_count;
                  end
               end
               if (nxt.running) begin
                  if (nxt.countdown <= TIMEOUT_BITS'(1)) begin
                     nxt.countdown = '0;
                     nxt.running   = 1'b0;
                     if (!nxt.idle) begin
                        nxt.idle  = 1'b1;
                        req_valid = 1'b1;
                        req_level = idle_level;
                     end
                  end else begin
                     nxt.countdown = nxt.countdown - TIMEOUT_BITS'(1);
                  end
               end
            end
            OP_ACTIVITY: begin
               if (!cur.night) begin
                  if (cur.idle) begin
                     nxt.idle  = 1'b0;
                     req_valid = 1'b1;
                     req_level = active_level;
                  end
                  nxt.running = restart_run;
                  if (restart_run) begin
                     nxt.countdown = restart_count;
                  end
               end
            end
            OP_SLEEP: begin
               if (!cur.idle) begin
                  nxt.idle    = 1'b1;
                  nxt.running = 1'b0;
                  req_valid   = 1'b1;
                  req_level   = idle_level;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      res.is_idle      = nxt.idle;
      res.night_active = nxt.night;
      res.idle_changed = (nxt.idle != cur.idle);
      res.bright_valid = req_valid;
      res.brightness   = req_level;
   end

endmodule
